>>> rtl/core/mvm_pkg.sv
// Shared constants, sequencer codes and interface types of the multirotor velocity model.
`default_nettype none
package mvm_pkg;

   localparam int FRAC_BITS_DEF        = 16;
   localparam int YAW_ACCEL_LIMIT_DEF  = 196608;
   localparam int RESP_ACCEL_LIMIT_DEF = 262144;
   localparam int RESP_JERK_LIMIT_DEF  = 655360;

   localparam int REQ_DW = 144;
   localparam int RSP_DW = 352;
   localparam int ACT_W  = 3;
   localparam int STS_W  = 2;
   localparam int CSR_IW = 3;
   localparam int CSR_DW = 31;

   localparam logic [ACT_W-1:0] ACT_STEP     = 3'd0;
   localparam logic [ACT_W-1:0] ACT_LOAD_POS = 3'd1;
   localparam logic [ACT_W-1:0] ACT_LOAD_VEL = 3'd2;
   localparam logic [ACT_W-1:0] ACT_LOAD_CMD = 3'd3;
   localparam logic [ACT_W-1:0] ACT_LOAD_ACC = 3'd4;

   localparam logic [STS_W-1:0] STS_OK      = 2'd0;
   localparam logic [STS_W-1:0] STS_ZERO_DT = 2'd1;
   localparam logic [STS_W-1:0] STS_SAT     = 2'd2;

   localparam logic [CSR_IW-1:0] REG_ALPHA  = 3'd0;
   localparam logic [CSR_IW-1:0] REG_ITAU   = 3'd1;
   localparam logic [CSR_IW-1:0] REG_ALXY   = 3'd2;
   localparam logic [CSR_IW-1:0] REG_ALZ    = 3'd3;
   localparam logic [CSR_IW-1:0] REG_SLXY   = 3'd4;
   localparam logic [CSR_IW-1:0] REG_SLZ    = 3'd5;
   localparam logic [CSR_IW-1:0] REG_YLIM   = 3'd6;
   localparam logic [CSR_IW-1:0] REG_MODE   = 3'd7;

   localparam int OPW = 6;
   localparam logic [OPW-1:0] OP_IDLE  = 6'd0;
   localparam logic [OPW-1:0] OP_DISP  = 6'd1;
   localparam logic [OPW-1:0] OP_LD    = 6'd2;
   localparam logic [OPW-1:0] OP_FIN   = 6'd3;
   localparam logic [OPW-1:0] OP_M_D0  = 6'd4;
   localparam logic [OPW-1:0] OP_M_D1  = 6'd5;
   localparam logic [OPW-1:0] OP_M_D2  = 6'd6;
   localparam logic [OPW-1:0] OP_M_D3  = 6'd7;
   localparam logic [OPW-1:0] OP_M_BZ  = 6'd8;
   localparam logic [OPW-1:0] OP_M_BY  = 6'd9;
   localparam logic [OPW-1:0] OP_M_BXY = 6'd10;
   localparam logic [OPW-1:0] OP_M_NB  = 6'd11;
   localparam logic [OPW-1:0] OP_N_AX  = 6'd12;
   localparam logic [OPW-1:0] OP_N_AY  = 6'd13;
   localparam logic [OPW-1:0] OP_N_UB  = 6'd14;
   localparam logic [OPW-1:0] OP_N_CMP = 6'd15;
   localparam logic [OPW-1:0] OP_N_QX  = 6'd16;
   localparam logic [OPW-1:0] OP_N_QY  = 6'd17;
   localparam logic [OPW-1:0] OP_N_SQ  = 6'd18;
   localparam logic [OPW-1:0] OP_N_SQW = 6'd19;
   localparam logic [OPW-1:0] OP_N_DX  = 6'd20;
   localparam logic [OPW-1:0] OP_N_DXW = 6'd21;
   localparam logic [OPW-1:0] OP_N_DY  = 6'd22;
   localparam logic [OPW-1:0] OP_N_DYW = 6'd23;
   localparam logic [OPW-1:0] OP_N_WB  = 6'd24;
   localparam logic [OPW-1:0] OP_A_CL  = 6'd25;
   localparam logic [OPW-1:0] OP_L_G   = 6'd26;
   localparam logic [OPW-1:0] OP_L_GW  = 6'd27;
   localparam logic [OPW-1:0] OP_L_M0  = 6'd28;
   localparam logic [OPW-1:0] OP_L_M1  = 6'd29;
   localparam logic [OPW-1:0] OP_L_M2  = 6'd30;
   localparam logic [OPW-1:0] OP_L_M3  = 6'd31;
   localparam logic [OPW-1:0] OP_J_D0  = 6'd32;
   localparam logic [OPW-1:0] OP_J_D1  = 6'd33;
   localparam logic [OPW-1:0] OP_J_D2  = 6'd34;
   localparam logic [OPW-1:0] OP_J_D3  = 6'd35;
   localparam logic [OPW-1:0] OP_J_CH  = 6'd36;
   localparam logic [OPW-1:0] OP_J_JB  = 6'd37;
   localparam logic [OPW-1:0] OP_J_AC  = 6'd38;
   localparam logic [OPW-1:0] OP_J_V0  = 6'd39;
   localparam logic [OPW-1:0] OP_J_V1  = 6'd40;
   localparam logic [OPW-1:0] OP_J_V2  = 6'd41;
   localparam logic [OPW-1:0] OP_J_V3  = 6'd42;
   localparam logic [OPW-1:0] OP_P_0   = 6'd43;
   localparam logic [OPW-1:0] OP_P_1   = 6'd44;
   localparam logic [OPW-1:0] OP_P_2   = 6'd45;
   localparam logic [OPW-1:0] OP_P_3   = 6'd46;
   localparam logic [OPW-1:0] OP_P_4   = 6'd47;

   typedef struct packed {
      logic [OPW-1:0] op;
      logic           take;
      logic           capture;
   } cmd_type;

   typedef struct packed {
      logic [ACT_W-1:0] act;
      logic             dt_zero;
      logic             mode;
      logic             need;
      logic             sq_done;
      logic             dv_done;
   } stat_type;

endpackage
`default_nettype wire

>>> rtl/core/mvm_sqrt.sv
// Iterative 64-bit integer square root, two radicand bits per cycle.
`default_nettype none
module mvm_sqrt (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] radicand,
   output logic [31:0]      root,
   output logic             done
);
   logic [63:0] x_ff, x_in, r_ff, r_in, bit_ff, bit_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [63:0] trial;

   always_comb begin
      trial   = r_ff + bit_ff;
      x_in    = x_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = radicand;
         r_in    = '0;
         bit_in  = 64'd1 << 62;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (x_ff >= trial) begin
            x_in = x_ff - trial;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff == 64'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign root = r_ff[31:0];
   assign done = done_ff;
endmodule
`default_nettype wire

>>> rtl/core/mvm_div.sv
// Restoring divider, 64 by 32 bits with a 32-bit quotient, one bit per cycle.
`default_nettype none
module mvm_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] dividend,
   input  wire logic [31:0] divisor,
   output logic [31:0]      quotient,
   output logic             done
);
   logic [31:0] rem_ff, rem_in, low_ff, low_in, q_ff, q_in, dvs_ff, dvs_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      trial   = {rem_ff, low_ff[31]};
      rem_in  = rem_ff;
      low_in  = low_ff;
      q_in    = q_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend[63:32];
         low_in  = dividend[31:0];
         dvs_in  = divisor;
         cnt_in  = '1;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         low_in = {low_ff[30:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = 32'(trial - {1'b0, dvs_ff});
            q_in   = {q_ff[30:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            q_in   = {q_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
      q_ff   <= q_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = q_ff;
   assign done     = done_ff;
endmodule
`default_nettype wire

>>> rtl/core/mvm_dpath.sv
// Datapath: model state, configuration, shared multiplier, norm limiter and result register.
`default_nettype none
module mvm_dpath #(
   parameter int FRAC_BITS        = mvm_pkg::FRAC_BITS_DEF,
   parameter int YAW_ACCEL_LIMIT  = mvm_pkg::YAW_ACCEL_LIMIT_DEF,
   parameter int RESP_ACCEL_LIMIT = mvm_pkg::RESP_ACCEL_LIMIT_DEF,
   parameter int RESP_JERK_LIMIT  = mvm_pkg::RESP_JERK_LIMIT_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire mvm_pkg::cmd_type              cmd,
   output mvm_pkg::stat_type                  stat,
   input  wire logic [mvm_pkg::REQ_DW-1:0]    req_tdata,
   input  wire logic [mvm_pkg::ACT_W-1:0]     req_tuser,
   input  wire logic                          csr_we,
   input  wire logic [mvm_pkg::CSR_IW-1:0]    csr_index,
   input  wire logic [mvm_pkg::CSR_DW-1:0]    csr_wdata,
   output logic [mvm_pkg::RSP_DW-1:0]         rsp_tdata,
   output logic [mvm_pkg::STS_W-1:0]          rsp_tuser
);
   import mvm_pkg::*;

   localparam int PW = 67;
   localparam int WW = 70;
   localparam int GW = FRAC_BITS + 1;

   function automatic logic signed [WW-1:0] rnd16(input logic signed [PW-1:0] v);
      logic signed [WW-1:0] w;
      w = WW'(v) + (WW'(1) <<< 15);
      return w >>> 16;
   endfunction

   function automatic logic signed [WW-1:0] rndf(input logic signed [PW-1:0] v);
      logic signed [WW-1:0] w;
      w = WW'(v) + (WW'(1) <<< (FRAC_BITS - 1));
      return w >>> FRAC_BITS;
   endfunction

   function automatic logic [32:0] sat33(input logic signed [WW-1:0] v);
      logic signed [WW-1:0] hi, lo;
      hi = WW'(32'sh7FFF_FFFF);
      lo = -hi - WW'(1);
      if (v > hi) begin
         return {1'b1, 32'h7FFF_FFFF};
      end
      if (v < lo) begin
         return {1'b1, 32'h8000_0000};
      end
      return {1'b0, v[31:0]};
   endfunction

   function automatic logic signed [31:0] clampb(input logic signed [WW-1:0] v,
                                                input logic [31:0] b);
      logic signed [WW-1:0] bs, nb;
      bs = $signed(WW'(b));
      nb = -bs;
      if (v > bs) begin
         return bs[31:0];
      end
      if (v < nb) begin
         return nb[31:0];
      end
      return v[31:0];
   endfunction

   function automatic logic [31:0] abs32(input logic signed [31:0] v);
      return v[31] ? 32'(~v + 32'sd1) : v;
   endfunction

   logic [16:0] alpha_ff, alpha_in;
   logic [30:0] itau_ff, itau_in, alxy_ff, alxy_in, alz_ff, alz_in;
   logic [30:0] slxy_ff, slxy_in, slz_ff, slz_in, ylim_ff, ylim_in;
   logic        mode_ff, mode_in;

   logic [ACT_W-1:0]   act_ff, act_in;
   logic signed [31:0] rq_ff [4];
   logic signed [31:0] rq_in [4];
   logic [15:0]        dt_ff, dt_in;

   logic signed [31:0] pos_ff [3];
   logic signed [31:0] pos_in [3];
   logic signed [31:0] vel_ff [3];
   logic signed [31:0] vel_in [3];
   logic signed [31:0] ac_ff [4];
   logic signed [31:0] ac_in [4];
   logic signed [31:0] am_ff [3];
   logic signed [31:0] am_in [3];
   logic signed [31:0] yaw_ff, yaw_in;
   logic [47:0]        et_ff, et_in;

   logic signed [PW-1:0] p_ff, p_in;
   logic signed [33:0]   mul_a;
   logic signed [32:0]   mul_b;
   logic signed [31:0]   nx_ff, nx_in, ny_ff, ny_in;
   logic [31:0]          nb_ff, nb_in;
   logic [63:0]          s_ff, s_in, pxu_ff, pxu_in, pyu_ff, pyu_in;
   logic                 need_ff, need_in;
   logic signed [35:0]   d2w_ff, d2w_in, d3w_ff, d3w_in;
   logic signed [31:0]   d2_ff, d2_in, d3_ff, d3_in, des2_ff, des2_in;
   logic [GW-1:0]        g_ff, g_in;
   logic [31:0]          qx_ff, qx_in;
   logic                 sat_ff, sat_in;
   logic [RSP_DW-1:0]    out_ff, out_in;
   logic [STS_W-1:0]     osts_ff, osts_in;

   logic [32:0]          sa, sb;
   logic signed [WW-1:0] gr;
   logic [31:0]          ax, ay;

   logic [31:0] sq_root, dv_q;
   logic        sq_done, dv_done;

   mvm_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.op == OP_N_SQ),
      .radicand (s_ff),
      .root     (sq_root),
      .done     (sq_done)
   );

   mvm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    ((cmd.op == OP_N_DX) || (cmd.op == OP_N_DY)),
      .dividend ((cmd.op == OP_N_DY) ? pyu_ff : pxu_ff),
      .divisor  (sq_root),
      .quotient (dv_q),
      .done     (dv_done)
   );

   assign ax   = abs32(nx_ff);
   assign ay   = abs32(ny_ff);
   assign p_in = mul_a * mul_b;

   always_comb begin
      alpha_in = alpha_ff;
      itau_in  = itau_ff;
      alxy_in  = alxy_ff;
      alz_in   = alz_ff;
      slxy_in  = slxy_ff;
      slz_in   = slz_ff;
      ylim_in  = ylim_ff;
      mode_in  = mode_ff;
      if (csr_we) begin
         case (csr_index)
            REG_ALPHA: alpha_in = csr_wdata[16:0];
            REG_ITAU:  itau_in  = csr_wdata;
            REG_ALXY:  alxy_in  = csr_wdata;
            REG_ALZ:   alz_in   = csr_wdata;
            REG_SLXY:  slxy_in  = csr_wdata;
            REG_SLZ:   slz_in   = csr_wdata;
            REG_YLIM:  ylim_in  = csr_wdata;
            REG_MODE:  mode_in  = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      act_in  = act_ff;
      rq_in   = rq_ff;
      dt_in   = dt_ff;
      pos_in  = pos_ff;
      vel_in  = vel_ff;
      ac_in   = ac_ff;
      am_in   = am_ff;
      yaw_in  = yaw_ff;
      et_in   = et_ff;
      nx_in   = nx_ff;
      ny_in   = ny_ff;
      nb_in   = nb_ff;
      s_in    = s_ff;
      pxu_in  = pxu_ff;
      pyu_in  = pyu_ff;
      need_in = need_ff;
      d2w_in  = d2w_ff;
      d3w_in  = d3w_ff;
      d2_in   = d2_ff;
      d3_in   = d3_ff;
      des2_in = des2_ff;
      g_in    = g_ff;
      qx_in   = qx_ff;
      sat_in  = sat_ff;
      out_in  = out_ff;
      osts_in = osts_ff;
      mul_a   = '0;
      mul_b   = '0;
      sa      = '0;
      sb      = '0;
      gr      = '0;

      if (cmd.take) begin
         act_in   = req_tuser;
         rq_in[0] = req_tdata[31:0];
         rq_in[1] = req_tdata[63:32];
         rq_in[2] = req_tdata[95:64];
         rq_in[3] = req_tdata[127:96];
         dt_in    = req_tdata[143:128];
         sat_in   = 1'b0;
      end

      if (cmd.capture) begin
         out_in = {ac_ff[3], ac_ff[2], ac_ff[1], ac_ff[0], yaw_ff,
                   vel_ff[2], vel_ff[1], vel_ff[0], pos_ff[2], pos_ff[1], pos_ff[0]};
         if (act_ff != ACT_STEP) begin
            osts_in = STS_OK;
         end else if (dt_ff == '0) begin
            osts_in = STS_ZERO_DT;
         end else if (sat_ff) begin
            osts_in = STS_SAT;
         end else begin
            osts_in = STS_OK;
         end
      end

      case (cmd.op)
         OP_LD: begin
            case (act_ff)
               ACT_LOAD_POS: begin
                  pos_in[0] = rq_ff[0];
                  pos_in[1] = rq_ff[1];
                  pos_in[2] = rq_ff[2];
                  yaw_in    = rq_ff[3];
               end
               ACT_LOAD_VEL: begin
                  vel_in[0] = rq_ff[0];
                  vel_in[1] = rq_ff[1];
                  vel_in[2] = rq_ff[2];
               end
               ACT_LOAD_CMD: begin
                  ac_in = rq_ff;
               end
               ACT_LOAD_ACC: begin
                  am_in[0] = rq_ff[0];
                  am_in[1] = rq_ff[1];
                  am_in[2] = rq_ff[2];
               end
               default: begin
               end
            endcase
         end
         OP_M_D0: begin
            mul_a = 34'(rq_ff[0]) - 34'(ac_ff[0]);
            mul_b = $signed(33'(alpha_ff));
         end
         OP_M_D1: begin
            sa     = sat33(rnd16(p_ff));
            nx_in  = sa[31:0];
            sat_in = sat_ff | sa[32];
            mul_a  = 34'(rq_ff[1]) - 34'(ac_ff[1]);
            mul_b  = $signed(33'(alpha_ff));
         end
         OP_M_D2: begin
            sa     = sat33(rnd16(p_ff));
            ny_in  = sa[31:0];
            sat_in = sat_ff | sa[32];
            mul_a  = 34'(rq_ff[2]) - 34'(ac_ff[2]);
            mul_b  = $signed(33'(alpha_ff));
         end
         OP_M_D3: begin
            d2w_in = 36'(rnd16(p_ff));
            mul_a  = 34'(rq_ff[3]) - 34'(ac_ff[3]);
            mul_b  = $signed(33'(alpha_ff));
         end
         OP_M_BZ: begin
            d3w_in = 36'(rnd16(p_ff));
            mul_a  = $signed(34'(alz_ff));
            mul_b  = $signed(33'(dt_ff));
         end
         OP_M_BY: begin
            d2_in = clampb(WW'(d2w_ff), 32'(rnd16(p_ff)));
            mul_a = $signed(34'(YAW_ACCEL_LIMIT));
            mul_b = $signed(33'(dt_ff));
         end
         OP_M_BXY: begin
            d3_in = clampb(WW'(d3w_ff), 32'(rnd16(p_ff)));
            mul_a = $signed(34'(alxy_ff));
            mul_b = $signed(33'(dt_ff));
         end
         OP_M_NB: begin
            nb_in = 32'(rnd16(p_ff));
         end
         OP_N_AX: begin
            mul_a = $signed(34'(ax));
            mul_b = $signed(33'(ax));
         end
         OP_N_AY: begin
            s_in  = 64'(p_ff);
            mul_a = $signed(34'(ay));
            mul_b = $signed(33'(ay));
         end
         OP_N_UB: begin
            s_in  = s_ff + 64'(p_ff);
            mul_a = $signed(34'(nb_ff));
            mul_b = $signed(33'(nb_ff));
         end
         OP_N_CMP: begin
            need_in = s_ff > 64'(p_ff);
            mul_a   = $signed(34'(ax));
            mul_b   = $signed(33'(nb_ff));
         end
         OP_N_QX: begin
            pxu_in = 64'(p_ff);
            mul_a  = $signed(34'(ay));
            mul_b  = $signed(33'(nb_ff));
         end
         OP_N_QY: begin
            pyu_in = 64'(p_ff);
         end
         OP_N_DY: begin
            qx_in = dv_q;
         end
         OP_N_WB: begin
            nx_in = nx_ff[31] ? 32'(-$signed(qx_ff)) : $signed(qx_ff);
            ny_in = ny_ff[31] ? 32'(-$signed(dv_q)) : $signed(dv_q);
         end
         OP_A_CL: begin
            ac_in[0] = clampb(WW'(ac_ff[0]) + WW'(nx_ff), 32'(slxy_ff));
            ac_in[1] = clampb(WW'(ac_ff[1]) + WW'(ny_ff), 32'(slxy_ff));
            ac_in[2] = clampb(WW'(ac_ff[2]) + WW'(d2_ff), 32'(slz_ff));
            ac_in[3] = clampb(WW'(ac_ff[3]) + WW'(d3_ff), 32'(ylim_ff));
         end
         OP_L_G: begin
            mul_a = $signed(34'(itau_ff));
            mul_b = $signed(33'(dt_ff));
         end
         OP_L_GW: begin
            gr   = rnd16(p_ff);
            g_in = (gr > (WW'(1) <<< FRAC_BITS)) ? GW'(1) << FRAC_BITS : GW'(gr);
         end
         OP_L_M0: begin
            mul_a = 34'(ac_ff[0]) - 34'(vel_ff[0]);
            mul_b = $signed(33'(g_ff));
         end
         OP_L_M1: begin
            sa        = sat33(WW'(vel_ff[0]) + rndf(p_ff));
            vel_in[0] = sa[31:0];
            sat_in    = sat_ff | sa[32];
            mul_a     = 34'(ac_ff[1]) - 34'(vel_ff[1]);
            mul_b     = $signed(33'(g_ff));
         end
         OP_L_M2: begin
            sa        = sat33(WW'(vel_ff[1]) + rndf(p_ff));
            vel_in[1] = sa[31:0];
            sat_in    = sat_ff | sa[32];
            mul_a     = 34'(ac_ff[2]) - 34'(vel_ff[2]);
            mul_b     = $signed(33'(g_ff));
         end
         OP_L_M3: begin
            sa        = sat33(WW'(vel_ff[2]) + rndf(p_ff));
            vel_in[2] = sa[31:0];
            sat_in    = sat_ff | sa[32];
            am_in[0]  = '0;
            am_in[1]  = '0;
            am_in[2]  = '0;
         end
         OP_J_D0: begin
            mul_a = 34'(ac_ff[0]) - 34'(vel_ff[0]);
            mul_b = $signed(33'(itau_ff));
         end
         OP_J_D1: begin
            sa     = sat33(rndf(p_ff));
            nx_in  = sa[31:0];
            sat_in = sat_ff | sa[32];
            mul_a  = 34'(ac_ff[1]) - 34'(vel_ff[1]);
            mul_b  = $signed(33'(itau_ff));
         end
         OP_J_D2: begin
            sa     = sat33(rndf(p_ff));
            ny_in  = sa[31:0];
            sat_in = sat_ff | sa[32];
            mul_a  = 34'(ac_ff[2]) - 34'(vel_ff[2]);
            mul_b  = $signed(33'(itau_ff));
         end
         OP_J_D3: begin
            sa      = sat33(rndf(p_ff));
            des2_in = sa[31:0];
            sat_in  = sat_ff | sa[32];
            nb_in   = 32'(RESP_ACCEL_LIMIT);
         end
         OP_J_CH: begin
            sa     = sat33(WW'(nx_ff) - WW'(am_ff[0]));
            sb     = sat33(WW'(ny_ff) - WW'(am_ff[1]));
            nx_in  = sa[31:0];
            ny_in  = sb[31:0];
            sat_in = sat_ff | sa[32] | sb[32];
            mul_a  = $signed(34'(RESP_JERK_LIMIT));
            mul_b  = $signed(33'(dt_ff));
         end
         OP_J_JB: begin
            nb_in = 32'(rnd16(p_ff));
         end
         OP_J_AC: begin
            sa       = sat33(WW'(am_ff[0]) + WW'(nx_ff));
            sb       = sat33(WW'(am_ff[1]) + WW'(ny_ff));
            am_in[0] = sa[31:0];
            am_in[1] = sb[31:0];
            am_in[2] = des2_ff;
            sat_in   = sat_ff | sa[32] | sb[32];
         end
         OP_J_V0: begin
            mul_a = 34'(am_ff[0]);
            mul_b = $signed(33'(dt_ff));
         end
         OP_J_V1: begin
            sa        = sat33(WW'(vel_ff[0]) + rnd16(p_ff));
            vel_in[0] = sa[31:0];
            sat_in    = sat_ff | sa[32];
            mul_a     = 34'(am_ff[1]);
            mul_b     = $signed(33'(dt_ff));
         end
         OP_J_V2: begin
            sa        = sat33(WW'(vel_ff[1]) + rnd16(p_ff));
            vel_in[1] = sa[31:0];
            sat_in    = sat_ff | sa[32];
            mul_a     = 34'(am_ff[2]);
            mul_b     = $signed(33'(dt_ff));
         end
         OP_J_V3: begin
            sa        = sat33(WW'(vel_ff[2]) + rnd16(p_ff));
            vel_in[2] = sa[31:0];
            sat_in    = sat_ff | sa[32];
         end
         OP_P_0: begin
            mul_a = 34'(vel_ff[0]);
            mul_b = $signed(33'(dt_ff));
         end
         OP_P_1: begin
            sa        = sat33(WW'(pos_ff[0]) + rnd16(p_ff));
            pos_in[0] = sa[31:0];
            sat_in    = sat_ff | sa[32];
            mul_a     = 34'(vel_ff[1]);
            mul_b     = $signed(33'(dt_ff));
         end
         OP_P_2: begin
            sa        = sat33(WW'(pos_ff[1]) + rnd16(p_ff));
            pos_in[1] = sa[31:0];
            sat_in    = sat_ff | sa[32];
            mul_a     = 34'(vel_ff[2]);
            mul_b     = $signed(33'(dt_ff));
         end
         OP_P_3: begin
            sa        = sat33(WW'(pos_ff[2]) + rnd16(p_ff));
            pos_in[2] = sa[31:0];
            sat_in    = sat_ff | sa[32];
            mul_a     = 34'(ac_ff[3]);
            mul_b     = $signed(33'(dt_ff));
         end
         OP_P_4: begin
            sa     = sat33(WW'(yaw_ff) + rnd16(p_ff));
            yaw_in = sa[31:0];
            sat_in = sat_ff | sa[32];
            et_in  = et_ff + 48'(dt_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      act_ff  <= act_in;
      rq_ff   <= rq_in;
      dt_ff   <= dt_in;
      p_ff    <= p_in;
      nx_ff   <= nx_in;
      ny_ff   <= ny_in;
      nb_ff   <= nb_in;
      s_ff    <= s_in;
      pxu_ff  <= pxu_in;
      pyu_ff  <= pyu_in;
      need_ff <= need_in;
      d2w_ff  <= d2w_in;
      d3w_ff  <= d3w_in;
      d2_ff   <= d2_in;
      d3_ff   <= d3_in;
      des2_ff <= des2_in;
      g_ff    <= g_in;
      qx_ff   <= qx_in;
      sat_ff  <= sat_in;
      out_ff  <= out_in;
      osts_ff <= osts_in;
      if (reset) begin
         alpha_ff <= 17'd65536;
         itau_ff  <= 31'd131072;
         alxy_ff  <= 31'd196608;
         alz_ff   <= 31'd131072;
         slxy_ff  <= 31'd327680;
         slz_ff   <= 31'd131072;
         ylim_ff  <= 31'd65536;
         mode_ff  <= 1'b0;
         pos_ff   <= '{default: '0};
         vel_ff   <= '{default: '0};
         ac_ff    <= '{default: '0};
         am_ff    <= '{default: '0};
         yaw_ff   <= '0;
         et_ff    <= '0;
      end else begin
         alpha_ff <= alpha_in;
         itau_ff  <= itau_in;
         alxy_ff  <= alxy_in;
         alz_ff   <= alz_in;
         slxy_ff  <= slxy_in;
         slz_ff   <= slz_in;
         ylim_ff  <= ylim_in;
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         vel_ff   <= vel_in;
         ac_ff    <= ac_in;
         am_ff    <= am_in;
         yaw_ff   <= yaw_in;
         et_ff    <= et_in;
      end
   end

   assign stat.act     = act_ff;
   assign stat.dt_zero = (dt_ff == '0);
   assign stat.mode    = mode_ff;
   assign stat.need    = need_ff;
   assign stat.sq_done = sq_done;
   assign stat.dv_done = dv_done;

   assign rsp_tdata = out_ff;
   assign rsp_tuser = osts_ff;
endmodule
`default_nettype wire

>>> rtl/core/mvm_ctrl.sv
// Controller: sequences loads and the step computation, and owns both handshakes.
`default_nettype none
module mvm_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output mvm_pkg::cmd_type       cmd,
   input  wire mvm_pkg::stat_type stat
);
   import mvm_pkg::*;

   localparam logic [1:0] NORM_CMD   = 2'd0;
   localparam logic [1:0] NORM_DES   = 2'd1;
   localparam logic [1:0] NORM_JERK  = 2'd2;

   logic [OPW-1:0] state_ff, state_in, ret_op;
   logic [1:0]     nsel_ff, nsel_in;
   logic           vld_ff, vld_in;
   logic           free;

   assign free = !vld_ff || rsp_tready;

   always_comb begin
      case (nsel_ff)
         NORM_CMD:  ret_op = OP_A_CL;
         NORM_DES:  ret_op = OP_J_CH;
         NORM_JERK: ret_op = OP_J_AC;
         default:   ret_op = OP_A_CL;
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      nsel_in     = nsel_ff;
      vld_in      = vld_ff && !rsp_tready;
      cmd.op      = state_ff;
      cmd.take    = 1'b0;
      cmd.capture = 1'b0;
      case (state_ff)
         OP_IDLE: begin
            if (req_tvalid) begin
               cmd.take = 1'b1;
               state_in = OP_DISP;
            end
         end
         OP_DISP: begin
            state_in = (stat.act == ACT_STEP && !stat.dt_zero) ? OP_M_D0 : OP_LD;
         end
         OP_LD:    state_in = OP_FIN;
         OP_FIN: begin
            if (free) begin
               cmd.capture = 1'b1;
               vld_in      = 1'b1;
               state_in    = OP_IDLE;
            end
         end
         OP_M_D0:  state_in = OP_M_D1;
         OP_M_D1:  state_in = OP_M_D2;
         OP_M_D2:  state_in = OP_M_D3;
         OP_M_D3:  state_in = OP_M_BZ;
         OP_M_BZ:  state_in = OP_M_BY;
         OP_M_BY:  state_in = OP_M_BXY;
         OP_M_BXY: state_in = OP_M_NB;
         OP_M_NB: begin
            nsel_in  = NORM_CMD;
            state_in = OP_N_AX;
         end
         OP_N_AX:  state_in = OP_N_AY;
         OP_N_AY:  state_in = OP_N_UB;
         OP_N_UB:  state_in = OP_N_CMP;
         OP_N_CMP: state_in = OP_N_QX;
         OP_N_QX:  state_in = OP_N_QY;
         OP_N_QY:  state_in = stat.need ? OP_N_SQ : ret_op;
         OP_N_SQ:  state_in = OP_N_SQW;
         OP_N_SQW: state_in = stat.sq_done ? OP_N_DX : OP_N_SQW;
         OP_N_DX:  state_in = OP_N_DXW;
         OP_N_DXW: state_in = stat.dv_done ? OP_N_DY : OP_N_DXW;
         OP_N_DY:  state_in = OP_N_DYW;
         OP_N_DYW: state_in = stat.dv_done ? OP_N_WB : OP_N_DYW;
         OP_N_WB:  state_in = ret_op;
         OP_A_CL:  state_in = stat.mode ? OP_J_D0 : OP_L_G;
         OP_L_G:   state_in = OP_L_GW;
         OP_L_GW:  state_in = OP_L_M0;
         OP_L_M0:  state_in = OP_L_M1;
         OP_L_M1:  state_in = OP_L_M2;
         OP_L_M2:  state_in = OP_L_M3;
         OP_L_M3:  state_in = OP_P_0;
         OP_J_D0:  state_in = OP_J_D1;
         OP_J_D1:  state_in = OP_J_D2;
         OP_J_D2:  state_in = OP_J_D3;
         OP_J_D3: begin
            nsel_in  = NORM_DES;
            state_in = OP_N_AX;
         end
         OP_J_CH:  state_in = OP_J_JB;
         OP_J_JB: begin
            nsel_in  = NORM_JERK;
            state_in = OP_N_AX;
         end
         OP_J_AC:  state_in = OP_J_V0;
         OP_J_V0:  state_in = OP_J_V1;
         OP_J_V1:  state_in = OP_J_V2;
         OP_J_V2:  state_in = OP_J_V3;
         OP_J_V3:  state_in = OP_P_0;
         OP_P_0:   state_in = OP_P_1;
         OP_P_1:   state_in = OP_P_2;
         OP_P_2:   state_in = OP_P_3;
         OP_P_3:   state_in = OP_P_4;
         OP_P_4:   state_in = OP_FIN;
         default:  state_in = OP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= OP_IDLE;
         nsel_ff  <= NORM_CMD;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         nsel_ff  <= nsel_in;
         vld_ff   <= vld_in;
      end
   end

   assign req_tready = (state_ff == OP_IDLE);
   assign rsp_tvalid = vld_ff;
endmodule
`default_nettype wire

>>> rtl/core/multirotor_velocity_model_step.sv
// Top level of the multirotor velocity model step block.
`default_nettype none
// One multirotor rollout state in signed fixed point. Each request beat (a load, a step
// or an unknown action) yields one response beat with the state after it. Loads, unknown
// actions and zero-dt steps pass from the accept state through dispatch and the load
// state to the finish state, where the result is captured. A step runs on one shared
// 34x33 multiplier, in the lag response or in the accel and jerk response; each horizontal
// norm limit that clips adds a square root and two divisions, each with its start and
// wait. The lag response has one norm limit, the accel and jerk response three. The
// result sits in an output register, so the next beat is taken while it waits; a
// finished item holds until that register is free.
module multirotor_velocity_model_step #(
   parameter int FRAC_BITS        = mvm_pkg::FRAC_BITS_DEF,
   parameter int YAW_ACCEL_LIMIT  = mvm_pkg::YAW_ACCEL_LIMIT_DEF,
   parameter int RESP_ACCEL_LIMIT = mvm_pkg::RESP_ACCEL_LIMIT_DEF,
   parameter int RESP_JERK_LIMIT  = mvm_pkg::RESP_JERK_LIMIT_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   // vec_x, vec_y, vec_z, scalar_in, dt
   input  wire logic [mvm_pkg::REQ_DW-1:0]  req_tdata,
   // action
   input  wire logic [mvm_pkg::ACT_W-1:0]   req_tuser,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, heading, cmd_vx, cmd_vy, cmd_vz, cmd_yaw_rate
   output logic [mvm_pkg::RSP_DW-1:0]       rsp_tdata,
   // status
   output logic [mvm_pkg::STS_W-1:0]        rsp_tuser,
   input  wire logic                        csr_we,
   input  wire logic [mvm_pkg::CSR_IW-1:0]  csr_index,
   input  wire logic [mvm_pkg::CSR_DW-1:0]  csr_wdata
);
   import mvm_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   mvm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   mvm_dpath #(
      .FRAC_BITS        (FRAC_BITS),
      .YAW_ACCEL_LIMIT  (YAW_ACCEL_LIMIT),
      .RESP_ACCEL_LIMIT (RESP_ACCEL_LIMIT),
      .RESP_JERK_LIMIT  (RESP_JERK_LIMIT)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );
endmodule
`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench for the multirotor velocity model step block.
module tb;
   import mvm_pkg::*;

   typedef struct {
      logic signed [31:0] pos[3];
      logic signed [31:0] vel[3];
      logic signed [31:0] hdg;
      logic signed [31:0] cmd[4];
      logic [1:0]         sts;
   } vstate_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DW-1:0] req_tdata = '0;
   logic [ACT_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DW-1:0] rsp_tdata;
   logic [STS_W-1:0] rsp_tuser;
   logic csr_we = 1'b0;
   logic [CSR_IW-1:0] csr_index = '0;
   logic [CSR_DW-1:0] csr_wdata = '0;

   multirotor_velocity_model_step dut (.*);

   always #10 clock = ~clock;

   longint m_alpha, m_itau, m_alxy, m_alz, m_slxy, m_slz, m_ylim, m_mode;
   longint m_pos[3], m_vel[3], m_yaw, m_cmd[4], m_acc[3];
   bit m_sat;

   vstate_type state_queue[$];
   int mismatches = 0;
   bit no_idle = 0;
   bit rsp_no_idle = 0;

   function automatic longint rnd_shift(longint v, int n);
      return (v + (64'sd1 <<< (n - 1))) >>> n;
   endfunction

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) begin
         m_sat = 1; return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         m_sat = 1; return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic longint clampb(longint v, longint b);
      if (v > b) return b;
      if (v < -b) return -b;
      return v;
   endfunction

   function automatic longint dtmul(longint x, longint dt);
      return rnd_shift(x * dt, 16);
   endfunction

   function automatic longint unsigned root64(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b; r = (r >> 1) + b;
         end else r >>= 1;
         b >>= 2;
      end
      return r;
   endfunction

   function automatic void norm_limit(inout longint x, inout longint y, input longint bound);
      longint unsigned ax, ay, ub, s, n;
      ax = x < 0 ? -x : x;
      ay = y < 0 ? -y : y;
      ub = bound;
      s = ax * ax + ay * ay;
      if (s > ub * ub) begin
         n = root64(s);
         x = x < 0 ? -longint'(ax * ub / n) : longint'(ax * ub / n);
         y = y < 0 ? -longint'(ay * ub / n) : longint'(ay * ub / n);
      end
   endfunction

   function automatic void advance_state(longint dt, longint rq[4]);
      longint d[4], a[4], vn[3], ac[3], des[3], ch[2], g;
      for (int i = 0; i < 4; i++) d[i] = rnd_shift((rq[i] - m_cmd[i]) * m_alpha, 16);
      ac = '{0, 0, 0};
      d[0] = sat32(d[0]);
      d[1] = sat32(d[1]);
      norm_limit(d[0], d[1], dtmul(m_alxy, dt));
      d[2] = clampb(d[2], dtmul(m_alz, dt));
      d[3] = clampb(d[3], dtmul(YAW_ACCEL_LIMIT_DEF, dt));
      a[0] = clampb(m_cmd[0] + d[0], m_slxy);
      a[1] = clampb(m_cmd[1] + d[1], m_slxy);
      a[2] = clampb(m_cmd[2] + d[2], m_slz);
      a[3] = clampb(m_cmd[3] + d[3], m_ylim);
      if (m_mode != 0) begin
         for (int i = 0; i < 3; i++) des[i] = sat32(rnd_shift((a[i] - m_vel[i]) * m_itau, 16));
         norm_limit(des[0], des[1], RESP_ACCEL_LIMIT_DEF);
         ch[0] = sat32(des[0] - m_acc[0]);
         ch[1] = sat32(des[1] - m_acc[1]);
         norm_limit(ch[0], ch[1], dtmul(RESP_JERK_LIMIT_DEF, dt));
         ac[0] = sat32(m_acc[0] + ch[0]);
         ac[1] = sat32(m_acc[1] + ch[1]);
         ac[2] = des[2];
         for (int i = 0; i < 3; i++) vn[i] = sat32(m_vel[i] + dtmul(ac[i], dt));
      end else begin
         g = dtmul(m_itau, dt);
         if (g > 65536) g = 65536;
         for (int i = 0; i < 3; i++) vn[i] = sat32(m_vel[i] + rnd_shift(g * (a[i] - m_vel[i]), 16));
      end
      for (int i = 0; i < 3; i++) begin
         m_vel[i] = vn[i];
         m_pos[i] = sat32(m_pos[i] + dtmul(vn[i], dt));
         m_acc[i] = ac[i];
      end
      m_yaw = sat32(m_yaw + dtmul(a[3], dt));
      for (int i = 0; i < 4; i++) m_cmd[i] = a[i];
   endfunction

   function automatic vstate_type predict_state(logic [ACT_W-1:0] act, logic signed [31:0] vx,
         logic signed [31:0] vy, logic signed [31:0] vz, logic signed [31:0] sc, logic [15:0] dt);
      vstate_type r;
      longint rq[4];
      rq = '{vx, vy, vz, sc};
      m_sat = 0;
      r.sts = STS_OK;
      case (act)
         ACT_STEP: begin
            if (dt == 0) r.sts = STS_ZERO_DT;
            else begin
               advance_state(dt, rq);
               if (m_sat) r.sts = STS_SAT;
            end
         end
         ACT_LOAD_POS: begin
            for (int i = 0; i < 3; i++) m_pos[i] = rq[i];
            m_yaw = sc;
         end
         ACT_LOAD_VEL: for (int i = 0; i < 3; i++) m_vel[i] = rq[i];
         ACT_LOAD_CMD: for (int i = 0; i < 4; i++) m_cmd[i] = rq[i];
         ACT_LOAD_ACC: for (int i = 0; i < 3; i++) m_acc[i] = rq[i];
         default: ;
      endcase
      for (int i = 0; i < 3; i++) begin
         r.pos[i] = m_pos[i]; r.vel[i] = m_vel[i];
      end
      r.hdg = m_yaw;
      for (int i = 0; i < 4; i++) r.cmd[i] = m_cmd[i];
      return r;
   endfunction

   task automatic send_beat(logic [ACT_W-1:0] act, logic [31:0] vx, logic [31:0] vy,
         logic [31:0] vz, logic [31:0] sc, logic [15:0] dt);
      while (!no_idle && $urandom_range(99) < 26) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {dt, sc, vz, vy, vx};
      state_queue.push_back(predict_state(act, vx, vy, vz, sc, dt));
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (state_queue.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IW-1:0] idx, longint val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_DW-1:0];
      @(posedge clock);
      case (idx)
         REG_ALPHA: m_alpha = val & 64'h1FFFF;
         REG_ITAU:  m_itau = val & 64'h7FFFFFFF;
         REG_ALXY:  m_alxy = val & 64'h7FFFFFFF;
         REG_ALZ:   m_alz = val & 64'h7FFFFFFF;
         REG_SLXY:  m_slxy = val & 64'h7FFFFFFF;
         REG_SLZ:   m_slz = val & 64'h7FFFFFFF;
         REG_YLIM:  m_ylim = val & 64'h7FFFFFFF;
         default:   m_mode = val & 1;
      endcase
   endtask

   task automatic set_regs(longint al, longint it, longint axy, longint az, longint sxy,
         longint sz, longint yl, longint md);
      write_reg(REG_ALPHA, al); write_reg(REG_ITAU, it); write_reg(REG_ALXY, axy);
      write_reg(REG_ALZ, az); write_reg(REG_SLXY, sxy); write_reg(REG_SLZ, sz);
      write_reg(REG_YLIM, yl); write_reg(REG_MODE, md);
      csr_we <= 1'b0;
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(5))
         0: return $urandom;
         1: return $urandom_range(1, 0) ? 32'h7FFFFFFF : 32'h80000000;
         default: return $signed($urandom_range(1 << 20)) - (1 << 19);
      endcase
   endfunction

   function automatic logic [15:0] rand_dt();
      case ($urandom_range(7))
         0: return 16'hFFFF;
         1: return 16'd0;
         2: return $urandom;
         default: return $urandom_range(1, 3000);
      endcase
   endfunction

   task automatic test_directed;
      send_beat(ACT_STEP, 32'h00050000, 32'hFFFD0000, 32'h00010000, 32'h00008000, 16'd6554);
      send_beat(ACT_STEP, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 16'hFFFF);
      send_beat(ACT_STEP, 32'h00010000, 32'h0, 32'h0, 32'h0, 16'd0);
      send_beat(ACT_LOAD_POS, 32'h7FFFFFF0, 32'h80000010, 32'h0, 32'h7FFFFFFF, 16'd1);
      send_beat(ACT_LOAD_VEL, 32'h7FFF0000, 32'h80000000, 32'h7FFFFFFF, 32'h0, 16'd0);
      send_beat(ACT_STEP, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 16'hFFFF);
      send_beat(ACT_LOAD_CMD, 32'hFFFFFFFF, 32'h1, 32'h80000000, 32'h7FFFFFFF, 16'hFFFF);
      send_beat(ACT_LOAD_ACC, 32'h00040000, 32'hFFFC0000, 32'h1, 32'h0, 16'd0);
      for (int a = 5; a < 8; a++) send_beat(a, $urandom, $urandom, $urandom, $urandom, $urandom);
      send_beat(ACT_STEP, 32'h0, 32'h0, 32'h0, 32'h0, 16'd1);
      drain();
      set_regs(65536, 131072, 196608, 131072, 327680, 131072, 65536, 1);
      send_beat(ACT_LOAD_ACC, 32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h0, 16'd0);
      send_beat(ACT_STEP, 32'h00100000, 32'hFFF00000, 32'h00100000, 32'h00010000, 16'd655);
      send_beat(ACT_STEP, 32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h0, 16'hFFFF);
      send_beat(ACT_STEP, 32'h0, 32'h0, 32'h0, 32'h0, 16'd0);
      drain();
   endtask

   task automatic test_random_phase(int count);
      logic [ACT_W-1:0] act;
      for (int n = 0; n < count; n++) begin
         act = $urandom_range(99) < 70 ? ACT_STEP : $urandom_range(7);
         send_beat(act, rand_word(), rand_word(), rand_word(), rand_word(), rand_dt());
      end
      drain();
   endtask

   task automatic test_config_sweep;
      set_regs(1, 1, 1, 1, 1, 1, 1, 0);
      test_random_phase(150);
      set_regs(131071, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
               32'h7FFFFFFF, 32'h7FFFFFFF, 1);
      test_random_phase(150);
      set_regs(0, 0, 0, 0, 0, 0, 0, 0);
      test_random_phase(100);
      for (int p = 0; p < 6; p++) begin
         set_regs($urandom_range(1, 65536), $urandom_range(1, 1 << 20),
                  $urandom_range(1, 1 << 21), $urandom_range(1, 1 << 21),
                  $urandom_range(1, 1 << 22), $urandom_range(1, 1 << 22),
                  $urandom_range(1, 1 << 20), p % 2);
         no_idle = (p == 2);
         rsp_no_idle = (p == 2);
         test_random_phase(150);
      end
      no_idle = 0;
      rsp_no_idle = 0;
   endtask

   always @(posedge clock) begin
      vstate_type e;
      logic [31:0] got[11];
      logic [31:0] want[11];
      bit bad;
      if (!reset) begin
         rsp_tready <= rsp_no_idle || ($urandom_range(99) >= 26);
         if (rsp_tvalid && rsp_tready) begin
            if (state_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response beat");
            end else begin
               e = state_queue.pop_front();
               want = '{e.pos[0], e.pos[1], e.pos[2], e.vel[0], e.vel[1], e.vel[2], e.hdg,
                        e.cmd[0], e.cmd[1], e.cmd[2], e.cmd[3]};
               bad = (rsp_tuser !== e.sts);
               for (int i = 0; i < 11; i++) begin
                  got[i] = rsp_tdata[32*i +: 32];
                  if (got[i] !== want[i]) bad = 1;
               end
               if (bad) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch: status exp %0d got %0d", e.sts, rsp_tuser);
                     for (int i = 0; i < 11; i++)
                        if (got[i] !== want[i])
                           $display("  field %0d exp %h got %h", i, want[i], got[i]);
                  end
               end
            end
         end
      end
   end

   initial begin
      m_alpha = 65536; m_itau = 131072; m_alxy = 196608; m_alz = 131072;
      m_slxy = 327680; m_slz = 131072; m_ylim = 65536; m_mode = 0;
      m_pos = '{0, 0, 0}; m_vel = '{0, 0, 0}; m_acc = '{0, 0, 0};
      m_cmd = '{0, 0, 0, 0}; m_yaw = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      set_regs(65536, 131072, 196608, 131072, 327680, 131072, 65536, 0);
      test_random_phase(250);
      test_config_sweep();
      if (mismatches == 0 && state_queue.size() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #200000000;
      $display("RESULT: ERROR");
      $finish;
   end
endmodule
